[src/mcpwm_pkg.sv]
// Package for the multichannel PWM generator: field widths, opcodes,
// default parameters and the per-channel control bundle. No dependencies.
package mcpwm_pkg;

  localparam int unsigned DEFAULT_CHANNELS     = 2;
  localparam int unsigned DEFAULT_PERIOD_TICKS = 100;

  localparam int unsigned FULL_PERCENT = 100;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned CHAN_W   = 1;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned LEVELS_W = 2;
  localparam int unsigned PHASE_W  = 7;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b1;

  typedef struct packed {
    logic tick;
    logic write;
    logic wrap;
  } ch_ctrl_t;

endpackage

[src/multichannel_pwm_generator.sv]
// Top level of the multichannel PWM generator: input register, period
// counter, channel array and result register. Depends on mcpwm_pkg, mcpwm_chan.
//
//   channel | ports                                        | direction
//   in      | in_valid in_stall in_opcode in_channel in_duty_percent | item in
//   out     | out_valid out_stall out_pin_levels out_phase  | result out
//
// One item per cycle sustained while the result is not stalled; each result
// follows its transfer in through the input register, then the result register.
// Reset clears the counter, all duties and levels, and both valid flags.
// A stalled result holds the result register; the input register still
// takes one more item, then in_stall rises until out_stall drops.
module multichannel_pwm_generator #(
  parameter int unsigned CHANNELS     = mcpwm_pkg::DEFAULT_CHANNELS,
  parameter int unsigned PERIOD_TICKS = mcpwm_pkg::DEFAULT_PERIOD_TICKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcpwm_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [mcpwm_pkg::CHAN_W-1:0]      in_channel,
  input  logic [mcpwm_pkg::DUTY_W-1:0]      in_duty_percent,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcpwm_pkg::LEVELS_W-1:0]    out_pin_levels,
  output logic [mcpwm_pkg::PHASE_W-1:0]     out_phase
);
  import mcpwm_pkg::*;

  localparam int unsigned CNT_W = $clog2(PERIOD_TICKS);

  logic                 s1_valid_r;
  logic [OPCODE_W-1:0]  s1_opcode_r;
  logic [CHAN_W-1:0]    s1_channel_r;
  logic [DUTY_W-1:0]    s1_duty_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W:0]       count_inc;
  logic                 advance;
  logic                 fire;
  logic                 is_tick;
  logic                 wrap;
  logic [CHANNELS-1:0]  level_nxt;
  logic [LEVELS_W+CHANNELS-1:0] levels_ext;
  logic [PHASE_W+CNT_W-1:0]     phase_ext;
  logic                 out_valid_r;
  logic [LEVELS_W-1:0]  out_pin_levels_r;
  logic [PHASE_W-1:0]   out_phase_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;
  assign is_tick  = (s1_opcode_r == OP_TICK);

  assign count_inc = {1'b0, count_r} + (CNT_W+1)'(1);
  assign wrap      = (count_inc >= (CNT_W+1)'(PERIOD_TICKS));

  always_comb begin
    count_nxt = count_r;
    if (fire && is_tick) begin
      count_nxt = wrap ? '0 : count_inc[CNT_W-1:0];
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    ch_ctrl_t ctrl;
    assign ctrl.tick  = fire && is_tick;
    assign ctrl.write = fire && (s1_opcode_r == OP_WRITE) && (32'(s1_channel_r) == k);
    assign ctrl.wrap  = wrap;

    mcpwm_chan #(
      .PERIOD_TICKS (PERIOD_TICKS),
      .CNT_W        (CNT_W)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .used      (count_r),
      .duty      (s1_duty_r),
      .level_nxt (level_nxt[k])
    );
  end

  assign levels_ext = {{LEVELS_W{1'b0}}, level_nxt};
  assign phase_ext  = {{PHASE_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      count_r <= count_nxt;
    end
    if (in_valid && !in_stall) begin
      s1_opcode_r  <= in_opcode;
      s1_channel_r <= in_channel;
      s1_duty_r    <= in_duty_percent;
    end
    if (fire) begin
      out_pin_levels_r <= levels_ext[LEVELS_W-1:0];
      out_phase_r      <= phase_ext[PHASE_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_pin_levels_r;
  assign out_phase      = out_phase_r;

endmodule

[src/mcpwm_chan.sv]
// One PWM channel: pending and active duty, output level.
// Depends on mcpwm_pkg.
module mcpwm_chan #(
  parameter int unsigned PERIOD_TICKS = mcpwm_pkg::DEFAULT_PERIOD_TICKS,
  parameter int unsigned CNT_W        = $clog2(PERIOD_TICKS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mcpwm_pkg::ch_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]          used,
  input  logic [mcpwm_pkg::DUTY_W-1:0] duty,
  output logic                      level_nxt
);
  import mcpwm_pkg::*;

  localparam int unsigned PROD_W = $clog2(FULL_PERCENT * PERIOD_TICKS + 1);

  logic [DUTY_W-1:0] pending_r, pending_nxt;
  logic [DUTY_W-1:0] active_r, active_nxt;
  logic              level_r;
  logic [CNT_W:0]    used_inc;
  logic [PROD_W-1:0] pos_scaled;
  logic [PROD_W-1:0] duty_scaled;

  assign used_inc    = {1'b0, used} + (CNT_W+1)'(1);
  assign pos_scaled  = PROD_W'(used_inc) * PROD_W'(FULL_PERCENT);
  assign duty_scaled = PROD_W'(active_r) * PROD_W'(PERIOD_TICKS);

  always_comb begin
    pending_nxt = pending_r;
    active_nxt  = active_r;
    level_nxt   = level_r;
    if (ctrl.write) begin
      pending_nxt = (duty > DUTY_W'(FULL_PERCENT)) ? DUTY_W'(FULL_PERCENT) : duty;
    end
    if (ctrl.tick) begin
      if (used == '0) begin
        if (active_r != '0) begin
          level_nxt = 1'b1;
        end
      end else if (pos_scaled > duty_scaled) begin
        level_nxt = 1'b0;
      end
      if (ctrl.wrap) begin
        active_nxt = pending_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      active_r  <= '0;
      level_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

[src/mcpwm_checker.sv]
// Port-level checker for the multichannel PWM generator, bound to the top.
// Depends on mcpwm_pkg and multichannel_pwm_generator.
module mcpwm_checker #(
  parameter int unsigned PERIOD_TICKS = mcpwm_pkg::DEFAULT_PERIOD_TICKS
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mcpwm_pkg::LEVELS_W-1:0] out_pin_levels,
  input logic [mcpwm_pkg::PHASE_W-1:0]  out_phase
);
  import mcpwm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pin_levels) && $stable(out_phase))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (PERIOD_TICKS > 128) || (32'(out_phase) < PERIOD_TICKS))
    else $error("phase beyond period");

endmodule

bind multichannel_pwm_generator mcpwm_checker #(
  .PERIOD_TICKS (PERIOD_TICKS)
) u_mcpwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pin_levels (out_pin_levels),
  .out_phase      (out_phase)
);
